/* rtl/mask_keypoint_snap_core_macros.svh */
// Assertion macros for the RTL files (included by mksnap_dp.sv).
// Assumes the enclosing module has i_clk and i_rst_n.
`ifndef MASK_KEYPOINT_SNAP_CORE_MACROS_SVH
`define MASK_KEYPOINT_SNAP_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define MKSNAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MKSNAP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MKSNAP_ASSERT(lbl, prop, msg)
`define MKSNAP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/mksnap_pkg.sv */
package mksnap_pkg;

    localparam int MAX_COLS_DEF   = 512;
    localparam int MAX_ROWS_DEF   = 512;
    localparam int MAX_RADIUS_DEF = 64;

    localparam int COORD_W   = 9;
    localparam int Q_W       = 16;
    localparam int AREA_W    = 10;
    localparam int AREA_RST  = 512;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic wr;
        logic query;
        logic direct;
        logic first_rad;
        logic win;
        logic scan;
        logic next_rad;
        logic emit;
    } t_mks_cmd;

    typedef struct packed {
        logic pix_bit;
        logic scan_last;
        logic pipe_busy;
        logic found;
        logic full_cover;
        logic rad_max;
        logic out_free;
    } t_mks_sts;

    // last usable index of an area register; 0 acts as 1, large values saturate
    function automatic int lim_top(input logic [AREA_W-1:0] v, input int maxv);
        int u;
        u = int'(v);
        if (u == 0) u = 1;
        if (u > maxv) u = maxv;
        return u - 1;
    endfunction

endpackage

/* rtl/mksnap_if.sv */
interface mksnap_in_if import mksnap_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [COORD_W-1:0]      pix_col;
    logic [COORD_W-1:0]      pix_row;
    logic                    pix_on;
    logic signed [Q_W-1:0]   kp_x;
    logic signed [Q_W-1:0]   kp_y;

    modport source(output valid, kind, pix_col, pix_row, pix_on, kp_x, kp_y, input ready);
    modport sink(input valid, kind, pix_col, pix_row, pix_on, kp_x, kp_y, output ready);
endinterface

interface mksnap_out_if import mksnap_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] snap_col;
    logic [COORD_W-1:0] snap_row;
    logic               found;
    logic               direct_hit;

    modport source(output valid, snap_col, snap_row, found, direct_hit, input ready);
    modport sink(input valid, snap_col, snap_row, found, direct_hit, output ready);
endinterface

interface mksnap_cfg_if import mksnap_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [AREA_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* rtl/mask_keypoint_snap_core.sv */
// Mask write: the core stays idle and takes the next request in the following cycle.
// Query, direct hit: LOAD, CHECK, DONE; emit waits in DONE until the output is free, then back to IDLE.
// Query, miss: per radius, WIN, a ring scan (one mask read a cycle), then DRAIN of the distance pipe;
//   clamped windows read fewer pixels. The result is registered at emit, as for a direct hit.
// Reset clears control state and sets both area registers to the full mask;
// mask contents are not cleared and read as undefined until written.
module mask_keypoint_snap_core import mksnap_pkg::*; #(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mksnap_in_if.sink     i_in,
    mksnap_cfg_if.sink    i_cfg,
    mksnap_out_if.source  o_out
);

    t_mks_cmd w_cmd;
    t_mks_sts w_sts;
    logic     w_in_ready;

    assign i_in.ready = w_in_ready;

    mksnap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mksnap_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_pix_col (i_in.pix_col),
        .i_pix_row (i_in.pix_row),
        .i_pix_on  (i_in.pix_on),
        .i_kp_x    (i_in.kp_x),
        .i_kp_y    (i_in.kp_y),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

/* rtl/mksnap_ctrl.sv */
module mksnap_ctrl import mksnap_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_kind,
    input  t_mks_sts i_sts,
    output logic     o_in_ready,
    output t_mks_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_WIN,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_state     = S_LOAD;
                    end
                end
            end
            S_LOAD: n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.pix_bit) begin
                    o_cmd.direct = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.first_rad = 1'b1;
                    n_state         = S_WIN;
                end
            end
            S_WIN: begin
                o_cmd.win = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                // wait for the distance pipe to settle before judging the window
                if (!i_sts.pipe_busy) begin
                    if (i_sts.found || i_sts.full_cover || i_sts.rad_max) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.next_rad = 1'b1;
                        n_state        = S_WIN;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/mksnap_dp.sv */
`include "mask_keypoint_snap_core_macros.svh"

module mksnap_dp import mksnap_pkg::*; #(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mks_cmd              i_cmd,
    output t_mks_sts              o_sts,
    input  logic [COORD_W-1:0]    i_pix_col,
    input  logic [COORD_W-1:0]    i_pix_row,
    input  logic                  i_pix_on,
    input  logic signed [Q_W-1:0] i_kp_x,
    input  logic signed [Q_W-1:0] i_kp_y,
    mksnap_cfg_if.sink            i_cfg,
    mksnap_out_if.source          o_out
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int KW    = (CW > RW) ? CW : RW;
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int KR    = (KW > RDW) ? KW : RDW;
    localparam int SW    = ((KR > Q_W - 4) ? KR : Q_W - 4) + 2;
    localparam int DW    = ((KW + 4 > Q_W) ? KW + 4 : Q_W) + 2;
    localparam int PW    = 2 * DW;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;

    localparam logic [CW-1:0] WTOP_RST = CW'(lim_top(AREA_W'(AREA_RST), MAX_COLS));
    localparam logic [RW-1:0] HTOP_RST = RW'(lim_top(AREA_W'(AREA_RST), MAX_ROWS));

    function automatic logic signed [SW-1:0] clamp_s(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] top);
        logic signed [SW-1:0] res;
        res = v;
        if (v < 0) res = '0;
        else if (v > top) res = top;
        return res;
    endfunction

    // mask memory, undefined until written
    logic r_mask [DEPTH];
    logic r_rd_bit;

    logic [CW-1:0] r_wtop;
    logic [RW-1:0] r_htop;

    logic [CW-1:0]         r_x;
    logic [RW-1:0]         r_y;
    logic signed [Q_W-1:0] r_qx;
    logic signed [Q_W-1:0] r_qy;
    logic [RDW-1:0]        r_rad;

    logic [CW-1:0]        r_c0, r_c1, r_c;
    logic [RW-1:0]        r_r0, r_r1, r_r;
    logic signed [SW-1:0] r_elo, r_ehi;

    logic          r_p1_v;
    logic [CW-1:0] r_p1_c;
    logic [RW-1:0] r_p1_r;

    logic          r_p2_v;
    logic          r_p2_hit;
    logic [CW-1:0] r_p2_c;
    logic [RW-1:0] r_p2_r;
    logic [PW-1:0] r_dx2, r_dy2;

    logic [PW-1:0] r_best;
    logic          r_found;
    logic          r_direct;
    logic [CW-1:0] r_bc;
    logic [RW-1:0] r_br;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;
    logic               r_out_found;
    logic               r_out_direct;

    logic signed [SW-1:0]    wtop_s, htop_s;
    logic signed [Q_W-5:0]   flx, fly;
    logic                    upx, upy;
    logic signed [SW-1:0]    rx, ry;
    logic [CW-1:0]           qx_c;
    logic [RW-1:0]           qy_c;
    logic signed [SW-1:0]    rad_s, xs, ys, lo_x, hi_x, lo_y, hi_y, cs;
    logic                    edge_col;
    logic                    wr_ok;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic signed [DW-1:0]    dx, dy;
    logic signed [PW-1:0]    dx2, dy2;
    logic [PW-1:0]           dsum;
    logic                    better;
    logic                    out_take;

    // round half to even, then clamp to the area in use
    assign wtop_s = SW'($signed({1'b0, r_wtop}));
    assign htop_s = SW'($signed({1'b0, r_htop}));
    assign flx    = i_kp_x[Q_W-1:4];
    assign fly    = i_kp_y[Q_W-1:4];
    assign upx    = (i_kp_x[3:0] > 4'd8) || (i_kp_x[3:0] == 4'd8 && flx[0]);
    assign upy    = (i_kp_y[3:0] > 4'd8) || (i_kp_y[3:0] == 4'd8 && fly[0]);
    assign rx     = SW'(flx) + SW'(upx);
    assign ry     = SW'(fly) + SW'(upy);
    assign qx_c   = CW'(clamp_s(rx, wtop_s));
    assign qy_c   = RW'(clamp_s(ry, htop_s));

    // window bounds around the rounded pixel
    assign rad_s = SW'({1'b0, r_rad});
    assign xs    = SW'({1'b0, r_x});
    assign ys    = SW'({1'b0, r_y});
    assign lo_x  = xs - rad_s;
    assign hi_x  = xs + rad_s;
    assign lo_y  = ys - rad_s;
    assign hi_y  = ys + rad_s;

    // only the ring is new at each radius; interior columns visit top and bottom rows
    assign cs       = SW'({1'b0, r_c});
    assign edge_col = (cs == r_elo) || (cs == r_ehi);

    assign wr_ok   = i_cmd.wr && (32'(i_pix_col) < MAX_COLS) && (32'(i_pix_row) < MAX_ROWS);
    assign wr_addr = {RW'(i_pix_row), CW'(i_pix_col)};
    assign rd_addr = i_cmd.scan ? {r_r, r_c} : {r_y, r_x};

    assign dx  = DW'($signed({1'b0, r_p1_c, 4'b0000})) - DW'(r_qx);
    assign dy  = DW'($signed({1'b0, r_p1_r, 4'b0000})) - DW'(r_qy);
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;

    assign dsum   = r_dx2 + r_dy2;
    assign better = r_p2_v && r_p2_hit && (!r_found || dsum < r_best);

    assign out_take = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mask[wr_addr] <= i_pix_on;
        r_rd_bit <= r_mask[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wtop      <= WTOP_RST;
            r_htop      <= HTOP_RST;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_COLS: r_wtop <= CW'(lim_top(i_cfg.data, MAX_COLS));
                    REG_ROWS: r_htop <= RW'(lim_top(i_cfg.data, MAX_ROWS));
                    default: ;
                endcase
            end
            r_p1_v <= i_cmd.scan;
            r_p2_v <= r_p1_v;
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (out_take) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_x      <= qx_c;
            r_y      <= qy_c;
            r_qx     <= i_kp_x;
            r_qy     <= i_kp_y;
            r_bc     <= qx_c;
            r_br     <= qy_c;
            r_found  <= 1'b0;
            r_direct <= 1'b0;
        end else if (i_cmd.direct) begin
            r_found  <= 1'b1;
            r_direct <= 1'b1;
        end else if (better) begin
            r_found <= 1'b1;
            r_best  <= dsum;
            r_bc    <= r_p2_c;
            r_br    <= r_p2_r;
        end

        if (i_cmd.first_rad) r_rad <= RDW'(1);
        else if (i_cmd.next_rad) r_rad <= r_rad + RDW'(1);

        if (i_cmd.win) begin
            r_c0  <= CW'(clamp_s(lo_x, wtop_s));
            r_c1  <= CW'(clamp_s(hi_x, wtop_s));
            r_r0  <= RW'(clamp_s(lo_y, htop_s));
            r_r1  <= RW'(clamp_s(hi_y, htop_s));
            r_c   <= CW'(clamp_s(lo_x, wtop_s));
            r_r   <= RW'(clamp_s(lo_y, htop_s));
            r_elo <= lo_x;
            r_ehi <= hi_x;
        end else if (i_cmd.scan) begin
            if (r_r == r_r1) begin
                r_c <= r_c + CW'(1);
                r_r <= r_r0;
            end else if (edge_col || r_r != r_r0) begin
                r_r <= r_r + RW'(1);
            end else begin
                r_r <= r_r1;
            end
        end

        r_p1_c <= r_c;
        r_p1_r <= r_r;

        r_p2_hit <= r_rd_bit;
        r_p2_c   <= r_p1_c;
        r_p2_r   <= r_p1_r;
        r_dx2    <= $unsigned(dx2);
        r_dy2    <= $unsigned(dy2);

        if (i_cmd.emit) begin
            r_out_col    <= COORD_W'(r_bc);
            r_out_row    <= COORD_W'(r_br);
            r_out_found  <= r_found;
            r_out_direct <= r_direct;
        end
    end

    assign o_sts.pix_bit    = r_rd_bit;
    assign o_sts.scan_last  = (r_r == r_r1) && (r_c == r_c1);
    assign o_sts.pipe_busy  = r_p1_v || r_p2_v;
    assign o_sts.found      = r_found;
    assign o_sts.full_cover = (r_c0 == '0) && (r_r0 == '0) &&
                              (r_c1 == r_wtop) && (r_r1 == r_htop);
    assign o_sts.rad_max    = (r_rad == RDW'(MAX_RADIUS));
    assign o_sts.out_free   = !r_out_valid || o_out.ready;

    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.snap_col   = r_out_col;
    assign o_out.snap_row   = r_out_row;
    assign o_out.found      = r_out_found;
    assign o_out.direct_hit = r_out_direct;

    `MKSNAP_ASSERT(a_rad_range, r_p1_v |-> (r_rad != '0 && 32'(r_rad) <= MAX_RADIUS), "radius out of range")
    `MKSNAP_ASSERT(a_scan_in_area, r_p1_v |-> (r_p1_c <= r_wtop && r_p1_r <= r_htop), "scan left area")
    `MKSNAP_ASSERT(a_emit_drained, i_cmd.emit |-> !(r_p1_v || r_p2_v), "result before pipe drained")
    `MKSNAP_ASSERT_ALWAYS(a_direct_found, (r_out_valid && r_out_direct) |-> r_out_found, "hit not found")

endmodule
